@@ hdl/hpg_pkg.sv @@
// Package for the Heap's-algorithm permutation generator.
// Holds the fixed port widths, the operation codes and the sequencer state type.
// No dependencies.
`default_nettype none

package hpg_pkg;

    // Fixed widths of the word fields.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 3;
    localparam int VAL_W   = 16;
    localparam int POS_W   = 3;
    localparam int COUNT_W = 4;

    // Operation codes carried by an input word.
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_NEXT    = 2'd2;

    // Reset value of the element count register.
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SW_RA,
        ST_SW_RB,
        ST_SW_WA,
        ST_SW_WB,
        ST_READ,
        ST_EMIT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

@@ hdl/heap_permutation_generator.sv @@
// Heap's-algorithm permutation generator, top level.
// Uses hpg_pkg (widths, op codes, state type) and instantiates hpg_store.
// The block holds up to MAX_ELEMENTS elements and produces every ordering of the
// first element_count of them with the iterative form of Heap's algorithm. A load
// word writes one element. A restart word clears the level counters and the flags
// and keeps the stored arrangement. A next word returns the arrangement as it
// stands right after a restart, and otherwise makes one swap and returns the new
// arrangement, one output word per element, position 0 first, with last set on the
// final element. After the final ordering every next word gives a single done word
// (position and element zero, last and done_res set). All work runs through one
// element store with one write port and one read port under a small sequencer, so
// the block takes one word at a time and drops o_ready until it is finished. A
// swapping next word passes through a start, a search that examines up to
// element_count - 1 level counters, a swap (two reads and two writes of the store)
// and the streaming of the elements, each read from the store's registered read
// port before it is emitted; a stalled output holds the stream. An element count
// of 0 acts as 1, and a count above MAX_ELEMENTS acts as MAX_ELEMENTS. Element
// values are kept at min(ELEMENT_WIDTH, 16) bits and read back zero-extended to
// the 16-bit element port.
`default_nettype none

module heap_permutation_generator #(
    parameter int MAX_ELEMENTS  = 8,
    parameter int ELEMENT_WIDTH = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [hpg_pkg::COUNT_W-1:0]         i_cfg_wr_data,
    input  wire logic                                i_valid,
    output      logic                                o_ready,
    input  wire logic [hpg_pkg::OP_W-1:0]            i_op,
    input  wire logic [hpg_pkg::IDX_W-1:0]           i_load_index,
    input  wire logic signed [hpg_pkg::VAL_W-1:0]    i_load_value,
    output      logic                                o_valid,
    input  wire logic                                i_ready,
    output      logic [hpg_pkg::POS_W-1:0]           o_position,
    output      logic signed [hpg_pkg::VAL_W-1:0]    o_element,
    output      logic                                o_last,
    output      logic                                o_done_res
);

    // Address width of the store, width of the level pointer and the active count.
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int LW = $clog2(MAX_ELEMENTS + 1);
    // Stored element width: the element port never shows more than 16 bits.
    localparam int SW = (ELEMENT_WIDTH < hpg_pkg::VAL_W) ? ELEMENT_WIDTH : hpg_pkg::VAL_W;

    hpg_pkg::t_state r_state, n_state;

    logic [hpg_pkg::COUNT_W-1:0] r_count;
    logic [AW-1:0]               r_cnt [MAX_ELEMENTS];
    logic [LW-1:0]               r_lv, n_lv;
    logic                        r_first, n_first;
    logic                        r_finished, n_finished;
    logic [AW-1:0]               r_pos, n_pos;
    logic [AW-1:0]               r_addr_a, n_addr_a;
    logic [AW-1:0]               r_addr_b, n_addr_b;
    logic [SW-1:0]               r_tmp;

    logic                        r_out_valid;
    logic [hpg_pkg::POS_W-1:0]   r_out_pos;
    logic [hpg_pkg::VAL_W-1:0]   r_out_elem;
    logic                        r_out_last;
    logic                        r_out_done;

    logic          accept;
    logic          out_free;
    logic [LW-1:0] active_n;
    logic [AW-1:0] cur_cnt;
    logic          pos_last;
    logic          load_ok;

    // Store port controls.
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [SW-1:0] st_wdata;
    logic [AW-1:0] st_raddr;
    logic [SW-1:0] st_rdata;

    // Level counter controls.
    logic cnt_clear;
    logic cnt_zero_lv;
    logic cnt_inc_lv;

    // Output register loads.
    logic out_load_elem;
    logic out_load_done;

    hpg_store #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH (SW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign o_ready  = (r_state == hpg_pkg::ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Clamp the configured count into 1..MAX_ELEMENTS.
    always_comb begin
        if (r_count == '0) begin
            active_n = LW'(1);
        end else if (32'(r_count) > MAX_ELEMENTS) begin
            active_n = LW'(MAX_ELEMENTS);
        end else begin
            active_n = LW'(r_count);
        end
    end

    assign cur_cnt  = r_cnt[r_lv[AW-1:0]];
    assign pos_last = (LW'(r_pos) == active_n - LW'(1));
    assign load_ok  = (32'(i_load_index) < MAX_ELEMENTS);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            hpg_pkg::ST_IDLE: begin
                if (accept && i_op == hpg_pkg::OP_NEXT) begin
                    if (r_finished) begin
                        n_state = hpg_pkg::ST_DONE;
                    end else if (!r_first) begin
                        n_state = hpg_pkg::ST_READ;
                    end else begin
                        n_state = hpg_pkg::ST_SEARCH;
                    end
                end
            end
            hpg_pkg::ST_SEARCH: begin
                if (r_lv >= active_n) begin
                    n_state = hpg_pkg::ST_DONE;
                end else if (LW'(cur_cnt) < r_lv) begin
                    n_state = hpg_pkg::ST_SW_RA;
                end
            end
            hpg_pkg::ST_SW_RA: n_state = hpg_pkg::ST_SW_RB;
            hpg_pkg::ST_SW_RB: n_state = hpg_pkg::ST_SW_WA;
            hpg_pkg::ST_SW_WA: n_state = hpg_pkg::ST_SW_WB;
            hpg_pkg::ST_SW_WB: n_state = hpg_pkg::ST_READ;
            hpg_pkg::ST_READ:  n_state = hpg_pkg::ST_EMIT;
            hpg_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = pos_last ? hpg_pkg::ST_IDLE : hpg_pkg::ST_READ;
                end
            end
            hpg_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = hpg_pkg::ST_IDLE;
                end
            end
            default: n_state = hpg_pkg::ST_IDLE;
        endcase
    end

    // Datapath and store controls.
    always_comb begin
        n_lv          = r_lv;
        n_first       = r_first;
        n_finished    = r_finished;
        n_pos         = r_pos;
        n_addr_a      = r_addr_a;
        n_addr_b      = r_addr_b;
        st_we         = 1'b0;
        st_waddr      = r_addr_a;
        st_wdata      = st_rdata;
        st_raddr      = r_pos;
        cnt_clear     = 1'b0;
        cnt_zero_lv   = 1'b0;
        cnt_inc_lv    = 1'b0;
        out_load_elem = 1'b0;
        out_load_done = 1'b0;
        case (r_state)
            hpg_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        hpg_pkg::OP_LOAD: begin
                            st_we    = load_ok;
                            st_waddr = AW'(i_load_index);
                            st_wdata = i_load_value[SW-1:0];
                        end
                        hpg_pkg::OP_RESTART: begin
                            cnt_clear  = 1'b1;
                            n_lv       = LW'(1);
                            n_first    = 1'b0;
                            n_finished = 1'b0;
                        end
                        hpg_pkg::OP_NEXT: begin
                            n_pos = '0;
                            if (!r_finished && !r_first) begin
                                n_first = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            hpg_pkg::ST_SEARCH: begin
                if (r_lv >= active_n) begin
                    n_finished = 1'b1;
                end else if (LW'(cur_cnt) < r_lv) begin
                    // Even levels swap with position 0, odd levels with the counter.
                    n_addr_a = r_lv[0] ? cur_cnt : '0;
                    n_addr_b = r_lv[AW-1:0];
                end else begin
                    cnt_zero_lv = 1'b1;
                    n_lv        = r_lv + LW'(1);
                end
            end
            hpg_pkg::ST_SW_RA: begin
                st_raddr = r_addr_a;
            end
            hpg_pkg::ST_SW_RB: begin
                st_raddr = r_addr_b;
            end
            hpg_pkg::ST_SW_WA: begin
                st_we    = 1'b1;
                st_waddr = r_addr_a;
                st_wdata = st_rdata;
            end
            hpg_pkg::ST_SW_WB: begin
                st_we      = 1'b1;
                st_waddr   = r_addr_b;
                st_wdata   = r_tmp;
                cnt_inc_lv = 1'b1;
                n_lv       = LW'(1);
                n_pos      = '0;
            end
            hpg_pkg::ST_READ: ;
            hpg_pkg::ST_EMIT: begin
                if (out_free) begin
                    out_load_elem = 1'b1;
                    if (!pos_last) begin
                        n_pos = r_pos + AW'(1);
                    end
                end
            end
            hpg_pkg::ST_DONE: begin
                out_load_done = out_free;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpg_pkg::ST_IDLE;
            r_count     <= hpg_pkg::COUNT_RESET;
            r_lv        <= LW'(1);
            r_first     <= 1'b0;
            r_finished  <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_ELEMENTS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_lv       <= n_lv;
            r_first    <= n_first;
            r_finished <= n_finished;
            r_pos      <= n_pos;
            if (i_cfg_wr_en) begin
                r_count <= i_cfg_wr_data;
            end
            if (cnt_clear) begin
                for (int i = 0; i < MAX_ELEMENTS; i++) begin
                    r_cnt[i] <= '0;
                end
            end else if (cnt_zero_lv) begin
                r_cnt[r_lv[AW-1:0]] <= '0;
            end else if (cnt_inc_lv) begin
                r_cnt[r_lv[AW-1:0]] <= cur_cnt + AW'(1);
            end
            if (out_load_elem || out_load_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr_a <= n_addr_a;
        r_addr_b <= n_addr_b;
        if (r_state == hpg_pkg::ST_SW_RB) begin
            r_tmp <= st_rdata;
        end
        if (out_load_elem) begin
            r_out_pos  <= hpg_pkg::POS_W'(r_pos);
            r_out_elem <= hpg_pkg::VAL_W'(st_rdata);
            r_out_last <= pos_last;
            r_out_done <= 1'b0;
        end else if (out_load_done) begin
            r_out_pos  <= '0;
            r_out_elem <= '0;
            r_out_last <= 1'b1;
            r_out_done <= 1'b1;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_position = r_out_pos;
    assign o_element  = r_out_elem;
    assign o_last     = r_out_last;
    assign o_done_res = r_out_done;

endmodule

`default_nettype wire

@@ hdl/hpg_store.sv @@
// Element store of the permutation generator: one write port, one read port.
// Read data is registered. Depends on nothing.
`default_nettype none

module hpg_store #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
